// ===== src/frame_word_checksum_check_or_seal_core_defines.svh =====
// assertion macros for the frame word checksum check or seal core
`ifndef FRAME_WORD_CHECKSUM_CHECK_OR_SEAL_CORE_DEFINES_SVH
`define FRAME_WORD_CHECKSUM_CHECK_OR_SEAL_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define FWCC_ASSERT_HOLDS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("fwcc assertion failed");
`define FWCC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fwcc assertion failed");
`else
`define FWCC_ASSERT_HOLDS(lbl, clk, rst_n, cond)
`define FWCC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== src/fwcc_pkg.sv =====
// shared types and constants of the frame word checksum check or seal core
package fwcc_pkg;

    localparam logic [7:0] FLAG_BYTE = 8'h7E;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_HEADER = 2'd1;
    localparam logic [1:0] ST_MISMATCH  = 2'd2;

    localparam logic [1:0] BEAT_LOW  = 2'd0;
    localparam logic [1:0] BEAT_HIGH = 2'd1;
    localparam logic [1:0] BEAT_FLAG = 2'd2;

    localparam int unsigned POS_W = 17;
    localparam logic [POS_W-1:0] POS_MAX = 17'h1FFFF;

    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic        seal;
        logic [1:0]  status;
        logic [15:0] sum;
    } t_event;

    typedef struct packed {
        logic              full;
        logic              empty;
        logic [QCNT_W-1:0] count;
    } t_queue_status;

endpackage

// ===== src/fwcc_ifs.sv =====
// channel interfaces of the frame word checksum check or seal core
interface fwcc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;
    logic       buffer_start;

    modport source (output valid, output byte_in, output buffer_start, input ready);
    modport sink (input valid, input byte_in, input buffer_start, output ready);
endinterface

interface fwcc_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic       is_trailer_byte;
    logic [7:0] out_byte;
    logic       last;

    modport source (output valid, output status, output is_trailer_byte,
                    output out_byte, output last, input ready);
    modport sink (input valid, input status, input is_trailer_byte,
                  input out_byte, input last, output ready);
endinterface

interface fwcc_cfg_if;
    logic valid;
    logic ready;
    logic check_mode;

    modport source (output valid, output check_mode, input ready);
    modport sink (input valid, input check_mode, output ready);
endinterface

// ===== src/frame_word_checksum_check_or_seal_core.sv =====
// top level of the frame word checksum check or seal core
//
//   channel  direction  payload
//   i_in     sink       byte_in, buffer_start
//   i_cfg    sink       check_mode
//   o_out    source     status, is_trailer_byte, out_byte, last
//
// one input byte per cycle while the event queue is not full
// a status result leaves as one transfer on o_out, a seal trailer as sum low, sum high and flag bytes
// a two-entry event queue separates the front from the output side
// synchronous active-low reset, no clearing pass; check_mode resets to 1
// output stalls fill the queue, then drop i_in.ready
`include "frame_word_checksum_check_or_seal_core_defines.svh"

module frame_word_checksum_check_or_seal_core #(
    parameter int unsigned HEADER_WINDOW = 9
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    fwcc_in_if.sink      i_in,
    fwcc_cfg_if.sink     i_cfg,
    fwcc_out_if.source   o_out
);

    logic                    push;
    logic                    pop;
    fwcc_pkg::t_event        push_event;
    fwcc_pkg::t_event        head_event;
    fwcc_pkg::t_queue_status q_status;

    fwcc_front #(
        .HEADER_WINDOW (HEADER_WINDOW)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_cfg   (i_cfg),
        .i_full  (q_status.full),
        .o_push  (push),
        .o_event (push_event)
    );

    fwcc_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_event),
        .i_pop       (pop),
        .o_head      (head_event),
        .o_status    (q_status)
    );

    fwcc_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (head_event),
        .i_status (q_status),
        .o_pop    (pop),
        .o_out    (o_out)
    );

    `FWCC_ASSERT_HOLDS(a_status_is_last, i_clk, i_rst_n, !o_out.valid || o_out.is_trailer_byte || o_out.last)
    `FWCC_ASSERT_HOLDS(a_error_not_trailer, i_clk, i_rst_n, !o_out.valid || o_out.status == fwcc_pkg::ST_OK || !o_out.is_trailer_byte)
    `FWCC_ASSERT_NEXT(a_push_grows_queue, i_clk, i_rst_n, push && !q_status.full && !pop, q_status.count == $past(q_status.count) + 2'd1)

endmodule

// ===== src/fwcc_front.sv =====
// front end: header search, count capture, word summing and event classification
module fwcc_front #(
    parameter int unsigned HEADER_WINDOW = 9
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    fwcc_in_if.sink            i_in,
    fwcc_cfg_if.sink           i_cfg,
    input  logic               i_full,
    output logic               o_push,
    output fwcc_pkg::t_event   o_event
);

    localparam int unsigned SC_W = $clog2(HEADER_WINDOW + 1);

    typedef enum logic [2:0] {
        PH_SEARCH = 3'b001,
        PH_SUM    = 3'b010,
        PH_DONE   = 3'b100
    } t_phase;

    t_phase                         r_phase, n_phase;
    logic [SC_W-1:0]                r_search_count, n_search_count;
    logic [fwcc_pkg::POS_W-1:0]     r_position, n_position;
    logic [15:0]                    r_byte_count, n_byte_count;
    logic [15:0]                    r_sum, n_sum;
    logic [7:0]                     r_held_low, n_held_low;
    logic [7:0]                     r_held_sum_low, n_held_sum_low;
    logic                           r_check_mode;

    logic                           accept;
    t_phase                         eff_phase;
    logic [SC_W-1:0]                eff_search;
    logic [SC_W-1:0]                search_inc;
    logic [15:0]                    word;
    logic [15:0]                    bc_now;
    logic [fwcc_pkg::POS_W-1:0]     bc17;
    logic [fwcc_pkg::POS_W-1:0]     last_word;
    logic [7:0]                     low_now;
    logic [7:0]                     b;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = !i_full;
    assign accept      = i_in.valid && !i_full;
    assign b           = i_in.byte_in;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_check_mode <= 1'b1;
        end else if (i_cfg.valid) begin
            r_check_mode <= i_cfg.check_mode;
        end
    end

    always_comb begin
        n_phase        = r_phase;
        n_search_count = r_search_count;
        n_position     = r_position;
        n_byte_count   = r_byte_count;
        n_sum          = r_sum;
        n_held_low     = r_held_low;
        n_held_sum_low = r_held_sum_low;
        o_push         = 1'b0;
        o_event        = '0;
        eff_phase      = i_in.buffer_start ? PH_SEARCH : r_phase;
        eff_search     = i_in.buffer_start ? '0 : r_search_count;
        search_inc     = eff_search + SC_W'(1);
        word           = {b, r_held_low};
        bc_now         = r_byte_count;
        bc17           = '0;
        last_word      = '0;
        low_now        = r_held_low;
        if (accept) begin
            n_phase        = eff_phase;
            n_search_count = eff_search;
            unique case (eff_phase)
                PH_SEARCH: begin
                    if (b == fwcc_pkg::FLAG_BYTE) begin
                        n_phase        = PH_SUM;
                        n_position     = '0;
                        n_byte_count   = '0;
                        n_sum          = '0;
                        n_held_low     = '0;
                        n_held_sum_low = '0;
                    end else begin
                        n_search_count = search_inc;
                        if (search_inc >= SC_W'(HEADER_WINDOW)) begin
                            n_phase        = PH_DONE;
                            o_push         = 1'b1;
                            o_event.status = fwcc_pkg::ST_NO_HEADER;
                        end
                    end
                end
                PH_SUM: begin
                    if (!r_position[0]) begin
                        n_held_low = b;
                        low_now    = b;
                    end else begin
                        if (r_position == fwcc_pkg::POS_W'(1)) begin
                            bc_now = word;
                        end
                        if ((r_position - fwcc_pkg::POS_W'(1)) < {1'b0, bc_now}) begin
                            n_sum = r_sum + word;
                        end
                    end
                    n_byte_count = bc_now;
                    bc17         = {1'b0, bc_now};
                    if (r_position != '0 && r_position == bc17) begin
                        n_held_sum_low = b;
                    end
                    if (bc_now == '0) begin
                        last_word = fwcc_pkg::POS_W'(1);
                    end else if (bc_now[0]) begin
                        last_word = bc17;
                    end else begin
                        last_word = bc17 - fwcc_pkg::POS_W'(1);
                    end
                    if (r_position != '0 && r_check_mode
                            && r_position >= bc17 + fwcc_pkg::POS_W'(1)) begin
                        n_phase        = PH_DONE;
                        o_push         = 1'b1;
                        o_event.status = (n_sum == {b, (bc_now == '0) ? low_now
                                                                : r_held_sum_low})
                                         ? fwcc_pkg::ST_OK : fwcc_pkg::ST_MISMATCH;
                    end else if (r_position != '0 && !r_check_mode
                            && r_position >= last_word) begin
                        n_phase      = PH_DONE;
                        o_push       = 1'b1;
                        o_event.seal = 1'b1;
                        o_event.sum  = n_sum;
                    end else if (r_position != fwcc_pkg::POS_MAX) begin
                        n_position = r_position + fwcc_pkg::POS_W'(1);
                    end
                end
                PH_DONE: begin
                end
                default: begin
                    n_phase = PH_SEARCH;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_SEARCH;
            r_search_count <= '0;
        end else begin
            r_phase        <= n_phase;
            r_search_count <= n_search_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_position     <= n_position;
        r_byte_count   <= n_byte_count;
        r_sum          <= n_sum;
        r_held_low     <= n_held_low;
        r_held_sum_low <= n_held_sum_low;
    end

endmodule

// ===== src/fwcc_queue.sv =====
// short event queue between front and back
module fwcc_queue (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    input  fwcc_pkg::t_event        i_push_data,
    input  logic                    i_pop,
    output fwcc_pkg::t_event        o_head,
    output fwcc_pkg::t_queue_status o_status
);

    fwcc_pkg::t_event                   r_mem [fwcc_pkg::QUEUE_DEPTH];
    logic [fwcc_pkg::QPTR_W-1:0]        r_wr_ptr, n_wr_ptr;
    logic [fwcc_pkg::QPTR_W-1:0]        r_rd_ptr, n_rd_ptr;
    logic [fwcc_pkg::QCNT_W-1:0]        r_count, n_count;
    logic                               do_push;
    logic                               do_pop;

    assign o_status.full  = r_count == fwcc_pkg::QCNT_W'(fwcc_pkg::QUEUE_DEPTH);
    assign o_status.empty = r_count == '0;
    assign o_status.count = r_count;
    assign o_head         = r_mem[r_rd_ptr];
    assign do_push        = i_push && !o_status.full;
    assign do_pop         = i_pop && !o_status.empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == fwcc_pkg::QPTR_W'(fwcc_pkg::QUEUE_DEPTH - 1))
                       ? '0 : r_wr_ptr + fwcc_pkg::QPTR_W'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == fwcc_pkg::QPTR_W'(fwcc_pkg::QUEUE_DEPTH - 1))
                       ? '0 : r_rd_ptr + fwcc_pkg::QPTR_W'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + fwcc_pkg::QCNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - fwcc_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

// ===== src/fwcc_back.sv =====
// back end: expands queued events into result transfers
module fwcc_back (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  fwcc_pkg::t_event        i_head,
    input  fwcc_pkg::t_queue_status i_status,
    output logic                    o_pop,
    fwcc_out_if.source              o_out
);

    logic [1:0] r_beat, n_beat;
    logic       xfer;

    assign o_out.valid = !i_status.empty;
    assign xfer        = o_out.valid && o_out.ready;
    assign o_pop       = xfer && o_out.last;

    always_comb begin
        o_out.status          = i_head.status;
        o_out.is_trailer_byte = 1'b0;
        o_out.out_byte        = '0;
        o_out.last            = 1'b1;
        if (i_head.seal) begin
            o_out.status          = fwcc_pkg::ST_OK;
            o_out.is_trailer_byte = 1'b1;
            o_out.last            = 1'b0;
            unique case (r_beat)
                fwcc_pkg::BEAT_LOW: begin
                    o_out.out_byte = i_head.sum[7:0];
                end
                fwcc_pkg::BEAT_HIGH: begin
                    o_out.out_byte = i_head.sum[15:8];
                end
                fwcc_pkg::BEAT_FLAG: begin
                    o_out.out_byte = fwcc_pkg::FLAG_BYTE;
                    o_out.last     = 1'b1;
                end
                default: begin
                    o_out.out_byte = fwcc_pkg::FLAG_BYTE;
                    o_out.last     = 1'b1;
                end
            endcase
        end
    end

    always_comb begin
        n_beat = r_beat;
        if (xfer) begin
            n_beat = o_out.last ? fwcc_pkg::BEAT_LOW : r_beat + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beat <= fwcc_pkg::BEAT_LOW;
        end else begin
            r_beat <= n_beat;
        end
    end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// testbench for the frame word checksum check or seal core
module tb;

    localparam int unsigned HDR_WINDOW = 9;
    localparam int unsigned SETTLE     = 8;
    localparam int unsigned LONG_HOLD  = 200;

    typedef enum logic [1:0] {HUNT, SUMMING, SETTLED} t_frame_phase;
    typedef enum logic [1:0] {BUF_GOOD, BUF_CUT, BUF_NOHDR, BUF_NOISE} t_buf_kind;

    typedef struct packed {
        logic [7:0] data;
        logic       first;
    } t_byte_item;

    typedef struct packed {
        logic [1:0] status;
        logic       trailer;
        logic [7:0] data;
        logic       last;
    } t_verdict;

    logic i_clk;
    logic i_rst_n;

    fwcc_in_if  in_if ();
    fwcc_cfg_if cfg_if ();
    fwcc_out_if out_if ();

    frame_word_checksum_check_or_seal_core #(
        .HEADER_WINDOW(HDR_WINDOW)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .i_cfg   (cfg_if),
        .o_out   (out_if)
    );

    t_byte_item byte_q[$];
    t_verdict   verdict_q[$];

    int errs = 0;
    int stim_items = 0;
    int verdicts_due = 0;
    int gap_left = 0;
    int burst_left = 0;
    int hold_reqs = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int rx_tick = 0;
    int rx_style = 0;
    logic in_xfer;
    logic rdy;
    t_byte_item next_byte;

    // frame tracker state
    logic                       fr_mode;
    t_frame_phase               fr_phase;
    logic [3:0]                 fr_seen;
    logic [fwcc_pkg::POS_W-1:0] fr_pos;
    logic [15:0]                fr_count;
    logic [15:0]                fr_sum;
    logic [7:0]                 fr_lo;
    logic [7:0]                 fr_ck_lo;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n = 1'b0;
        in_if.valid = 1'b0;
        in_if.byte_in = '0;
        in_if.buffer_start = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.check_mode = 1'b1;
        out_if.ready = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
    end

    initial begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("%0t mismatch: %s", $time, msg);
        errs++;
    endtask

    function automatic void owe(input logic [1:0] st, input logic tr, input logic [7:0] d,
                                input logic l);
        t_verdict v;
        v = '{status: st, trailer: tr, data: d, last: l};
        verdict_q.push_back(v);
    endfunction

    task automatic frame_step(input logic [7:0] b, input logic first);
        logic [15:0]                word;
        logic [fwcc_pkg::POS_W-1:0] last_word;
        logic [7:0]                 ck_low;
        logic                       fired;
        fired = 1'b0;
        if (first) begin
            fr_phase = HUNT;
            fr_seen = '0;
        end
        if (fr_phase == HUNT) begin
            if (b == fwcc_pkg::FLAG_BYTE) begin
                fr_phase = SUMMING;
                fr_pos = '0;
                fr_count = '0;
                fr_sum = '0;
                fr_lo = '0;
                fr_ck_lo = '0;
            end else begin
                fr_seen = fr_seen + 1'b1;
                if (fr_seen >= HDR_WINDOW) begin
                    fr_phase = SETTLED;
                    owe(fwcc_pkg::ST_NO_HEADER, 1'b0, 8'h00, 1'b1);
                end
            end
        end else if (fr_phase == SUMMING) begin
            if (!fr_pos[0]) begin
                fr_lo = b;
            end else begin
                word = {b, fr_lo};
                if (fr_pos == fwcc_pkg::POS_W'(1)) fr_count = word;
                if (fr_pos - 1'b1 < {1'b0, fr_count}) fr_sum = fr_sum + word;
            end
            if (fr_pos != 0 && fr_pos == {1'b0, fr_count}) fr_ck_lo = b;
            if (fr_pos != 0) begin
                if (fr_count == 0) last_word = fwcc_pkg::POS_W'(1);
                else if (fr_count[0]) last_word = {1'b0, fr_count};
                else last_word = {1'b0, fr_count} - 1'b1;
                if (fr_mode) begin
                    if (fr_pos >= {1'b0, fr_count} + 1'b1) begin
                        ck_low = (fr_count == 0) ? fr_lo : fr_ck_lo;
                        owe((fr_sum == {b, ck_low}) ? fwcc_pkg::ST_OK : fwcc_pkg::ST_MISMATCH,
                            1'b0, 8'h00, 1'b1);
                        fired = 1'b1;
                    end
                end else if (fr_pos >= last_word) begin
                    owe(fwcc_pkg::ST_OK, 1'b1, fr_sum[7:0], 1'b0);
                    owe(fwcc_pkg::ST_OK, 1'b1, fr_sum[15:8], 1'b0);
                    owe(fwcc_pkg::ST_OK, 1'b1, fwcc_pkg::FLAG_BYTE, 1'b1);
                    fired = 1'b1;
                end
            end
            if (fired) fr_phase = SETTLED;
            else if (fr_pos != fwcc_pkg::POS_MAX) fr_pos = fr_pos + 1'b1;
        end
    endtask

    task automatic compare_beat(input logic [1:0] st, input logic tr, input logic [7:0] d,
                                input logic l);
        t_verdict w;
        if (verdict_q.size() == 0) begin
            report_mismatch($sformatf("unexpected result status=%0d trailer=%0b byte=%02h last=%0b",
                                      st, tr, d, l));
        end else begin
            w = verdict_q.pop_front();
            if (st !== w.status)
                report_mismatch($sformatf("status got %0d want %0d", st, w.status));
            if (tr !== w.trailer)
                report_mismatch($sformatf("is_trailer_byte got %0b want %0b", tr, w.trailer));
            if (d !== w.data)
                report_mismatch($sformatf("out_byte got %02h want %02h", d, w.data));
            if (l !== w.last)
                report_mismatch($sformatf("last got %0b want %0b", l, w.last));
        end
    endtask

    // monitor and tracker
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_xfer <= 1'b0;
            fr_mode = 1'b1;
            fr_phase = HUNT;
            fr_seen = '0;
            fr_pos = '0;
            fr_count = '0;
            fr_sum = '0;
            fr_lo = '0;
            fr_ck_lo = '0;
        end else begin
            in_xfer <= in_if.valid && in_if.ready;
            if (in_if.valid && in_if.ready) frame_step(in_if.byte_in, in_if.buffer_start);
            if (out_if.valid && out_if.ready)
                compare_beat(out_if.status, out_if.is_trailer_byte, out_if.out_byte, out_if.last);
        end
    end

    // byte driver, bursts with gaps
    always @(negedge i_clk) begin
        if (i_rst_n && (!in_if.valid || in_xfer)) begin
            if (gap_left > 0) begin
                gap_left--;
                in_if.valid <= 1'b0;
            end else if (byte_q.size() > 0) begin
                next_byte = byte_q.pop_front();
                in_if.valid <= 1'b1;
                in_if.byte_in <= next_byte.data;
                in_if.buffer_start <= next_byte.first;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // result receiver with its own stall pattern and long holds on request
    always @(negedge i_clk) begin
        rx_tick++;
        if (rx_tick % 64 == 0) rx_style = $urandom_range(0, 2);
        if (hold_seen != hold_reqs) begin
            hold_seen = hold_reqs;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            rdy = 1'b0;
        end else begin
            case (rx_style)
                0: rdy = 1'b1;
                1: rdy = ($urandom_range(0, 3) != 0);
                default: rdy = ((rx_tick % 7) < 4);
            endcase
        end
        out_if.ready <= rdy;
    end

    task automatic queue_byte(input logic [7:0] b, input logic first);
        byte_q.push_back({b, first});
    endtask

    function automatic logic [7:0] plain_byte();
        logic [7:0] v;
        v = 8'($urandom_range(0, 255));
        if (v == fwcc_pkg::FLAG_BYTE) v = ~v;
        return v;
    endfunction

    task automatic wait_drained();
        do @(posedge i_clk);
        while (byte_q.size() != 0 || in_if.valid || verdict_q.size() != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_mode(input logic m);
        @(negedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.check_mode <= m;
        do @(posedge i_clk);
        while (!cfg_if.ready);
        fr_mode = m;
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic queue_frame(input logic seal, input t_buf_kind kind);
        logic [7:0]  body[$];
        logic [15:0] acc;
        int count, lead, span, i;
        case (kind)
            BUF_NOHDR: begin
                for (i = 0; i < HDR_WINDOW; i++) queue_byte(plain_byte(), i == 0);
                stim_items += HDR_WINDOW;
                verdicts_due++;
            end
            BUF_NOISE: begin
                span = $urandom_range(1, 12);
                for (i = 0; i < span; i++)
                    queue_byte(8'($urandom_range(0, 255)), i == 0 || $urandom_range(0, 7) == 0);
                stim_items += span;
            end
            default: begin
                i = $urandom_range(0, 99);
                count = (i < 80) ? $urandom_range(0, 10) :
                        (i < 97) ? $urandom_range(11, 40) : $urandom_range(256, 300);
                lead = ($urandom_range(0, 9) < 6) ? 0 : $urandom_range(1, HDR_WINDOW - 1);
                for (i = 0; i < lead; i++) queue_byte(plain_byte(), i == 0);
                queue_byte(fwcc_pkg::FLAG_BYTE, lead == 0);
                body.push_back(count[7:0]);
                body.push_back(count[15:8]);
                if (seal) span = (count == 0) ? 2 : (count % 2) ? count + 1 : count;
                else span = count + 2;
                while (body.size() < span) body.push_back(8'($urandom_range(0, 255)));
                if (!seal && count >= 2) begin
                    acc = '0;
                    for (i = 1; i < count; i += 2) acc += {body[i], body[i-1]};
                    // odd count: the checksum low byte is also the high half of the last word
                    if (count % 2) begin
                        body[count] = acc[7:0] + body[count-1];
                        acc += {body[count], body[count-1]};
                    end else begin
                        body[count] = acc[7:0];
                    end
                    body[count+1] = acc[15:8];
                    if ($urandom_range(0, 4) == 0) begin
                        i = $urandom_range(2, count + 1);
                        body[i] = body[i] ^ 8'($urandom_range(1, 255));
                    end
                end
                if (kind == BUF_CUT) span = $urandom_range(0, span - 1);
                else verdicts_due++;
                for (i = 0; i < span; i++) queue_byte(body[i], 1'b0);
                stim_items += lead + 1 + span;
                // ignored bytes after a finished buffer
                if (kind == BUF_GOOD && $urandom_range(0, 6) == 0)
                    repeat ($urandom_range(1, 3)) queue_byte(8'($urandom_range(0, 255)), 1'b0);
            end
        endcase
    endtask

    initial begin
        int ph, ph_start, pick;
        logic mode;
        t_buf_kind kind;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);

        // check mode from reset: first byte after reset opens a buffer, count zero
        queue_byte(fwcc_pkg::FLAG_BYTE, 1'b0);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'hFF, 1'b0);
        // no header within the window
        queue_byte(8'h00, 1'b1);
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'h7F, 1'b0);
        queue_byte(8'h80, 1'b0);
        queue_byte(8'h01, 1'b0);
        queue_byte(8'hFE, 1'b0);
        queue_byte(8'h7D, 1'b0);
        queue_byte(8'h55, 1'b0);
        queue_byte(8'hAA, 1'b0);
        // checksum overlapping the count field
        queue_byte(fwcc_pkg::FLAG_BYTE, 1'b1);
        queue_byte(8'h01, 1'b0);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'hAB, 1'b0);
        wait_drained();

        write_mode(1'b0);
        queue_byte(fwcc_pkg::FLAG_BYTE, 1'b1);
        queue_byte(8'h00, 1'b0);
        queue_byte(8'h00, 1'b0);
        queue_byte(fwcc_pkg::FLAG_BYTE, 1'b1);
        queue_byte(8'h04, 1'b0);
        queue_byte(8'h00, 1'b0);
        wait_drained();

        // mode switched in the middle of a buffer
        write_mode(1'b1);
        queue_byte(8'hAA, 1'b0);
        queue_byte(8'hBB, 1'b0);
        queue_byte(8'hAE, 1'b0);
        queue_byte(8'hBB, 1'b0);

        for (ph = 0; ph < 20 && stim_items < 200; ph++) begin
            mode = (ph == 0) ? 1'b0 : (ph == 1) ? 1'b1 : 1'($urandom_range(0, 1));
            wait_drained();
            write_mode(mode);
            ph_start = stim_items;
            while (stim_items - ph_start < 35) begin
                pick = $urandom_range(0, 99);
                kind = (pick < 70) ? BUF_GOOD : (pick < 80) ? BUF_CUT :
                       (pick < 88) ? BUF_NOHDR : BUF_NOISE;
                queue_frame(!mode, kind);
            end
            if (ph % 4 == 1) hold_reqs++;
        end

        wait_drained();
        if (errs == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
